FILE: rtl/aes_pkg.sv
// Shared types, constants and byte functions for the AES block cipher.
// Depends on nothing; the key expansion, round-key store, round and top level import it.
package aes_pkg;

    // Key size codes; code 3 behaves like the 256-bit key.
    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    localparam int BANKS      = 4;
    localparam int BANK_DEPTH = 15;

    typedef logic [3:0] rk_addr_t;

    // Write request from the key expansion into the round-key store.
    typedef struct packed {
        logic        en;
        logic [1:0]  bank;
        rk_addr_t    addr;
        logic [31:0] data;
    } rk_wr_t;

    localparam logic [7:0] SBOX_FWD [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [0:255] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Column mixing coefficients for row zero; later rows rotate them.
    localparam logic [3:0] MIX_FWD [0:3] = '{4'h2, 4'h3, 4'h1, 4'h1};
    localparam logic [3:0] MIX_INV [0:3] = '{4'he, 4'hb, 4'hd, 4'h9};

    // Multiplication by x in GF(2^8) with the AES polynomial.
    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Multiplication by a constant of at most four bits.
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [3:0] c);
        logic [7:0] acc;
        logic [7:0] p;
        acc = 8'h00;
        p   = x;
        for (int b = 0; b < 4; b++)
        begin
            if (c[b])
            begin
                acc = acc ^ p;
            end
            p = xtime(p);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
    endfunction

    // Number of rounds for a key size code.
    function automatic logic [3:0] round_count(input logic [1:0] ks);
        logic [3:0] nr;
        unique case (ks)
            KEY_128: nr = 4'd10;
            KEY_192: nr = 4'd12;
            default: nr = 4'd14;
        endcase
        return nr;
    endfunction

endpackage

FILE: rtl/aes_in_if.sv
// Input channel of the AES block cipher: opcode and one 128-bit block.
// Depends on nothing.
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] block_upper;
    logic [63:0] block_lower;

    modport source (output valid, output opcode, output block_upper, output block_lower,
                    input ready);
    modport sink (input valid, input opcode, input block_upper, input block_lower,
                  output ready);
endinterface

FILE: rtl/aes_out_if.sv
// Output channel of the AES block cipher: one 128-bit result block.
// Depends on nothing.
interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_upper;
    logic [63:0] out_lower;

    modport source (output valid, output out_upper, output out_lower, input ready);
    modport sink (input valid, input out_upper, input out_lower, output ready);
endinterface

FILE: rtl/aes_key_expand.sv
// Key expansion sequencer: one round-key word per cycle into the store.
// Depends on aes_pkg.
module aes_key_expand (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      key_size,
    input  logic [63:0]     key_word [0:3],
    output logic            busy,
    output aes_pkg::rk_wr_t wr
);
    import aes_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] win_reg [0:7];
    logic [2:0]  nk_last;
    logic [5:0]  total_last;
    logic [31:0] word;
    logic [31:0] old_word;
    logic [31:0] t;
    logic [63:0] kw;

    // Key length in words minus one and index of the last word.
    always_comb
    begin
        unique case (key_size)
            KEY_128: begin nk_last = 3'd3; total_last = 6'd43; end
            KEY_192: begin nk_last = 3'd5; total_last = 6'd51; end
            default: begin nk_last = 3'd7; total_last = 6'd59; end
        endcase
    end

    // Next schedule word: a copied key word, or the recurrence on the window.
    always_comb
    begin
        kw        = key_word[idx_reg[2:1]];
        old_word  = win_reg[nk_last];
        t         = win_reg[0];
        rcon_next = rcon_reg;
        if (phase_reg == 3'd0)
        begin
            t = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h000000};
        end
        else if (nk_last == 3'd7 && phase_reg == 3'd4)
        begin
            t = sub_word(win_reg[0]);
        end
        if ({3'b000, idx_reg[5:3]} == 6'd0 && idx_reg[2:0] <= nk_last)
        begin
            word = idx_reg[0] ? kw[31:0] : kw[63:32];
        end
        else
        begin
            word = old_word ^ t;
            if (phase_reg == 3'd0)
            begin
                rcon_next = xtime(rcon_reg);
            end
        end
    end

    // Sequencer control.
    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            idx_next   = 6'd0;
            phase_next = 3'd0;
        end
        else if (busy_reg)
        begin
            idx_next   = idx_reg + 6'd1;
            phase_next = (phase_reg == nk_last) ? 3'd0 : phase_reg + 3'd1;
            if (idx_reg == total_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            idx_reg   <= 6'd0;
            phase_reg <= 3'd0;
            rcon_reg  <= 8'h01;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            if (start)
            begin
                rcon_reg <= 8'h01;
            end
            else if (busy_reg)
            begin
                rcon_reg <= rcon_next;
            end
        end
    end

    // Window of the most recent eight words, newest first.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            win_reg[0] <= word;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k - 1];
            end
        end
    end

    assign busy    = busy_reg;
    assign wr.en   = busy_reg && !start;
    assign wr.bank = idx_reg[1:0];
    assign wr.addr = idx_reg[5:2];
    assign wr.data = word;

endmodule

FILE: rtl/aes_rk_store.sv
// Round-key store: four banks of 32-bit words, one bank per state column.
// Depends on aes_pkg.
module aes_rk_store (
    input  logic              clk,
    input  aes_pkg::rk_wr_t   wr,
    input  aes_pkg::rk_addr_t rd_addr,
    output logic [127:0]      rd_data
);
    import aes_pkg::*;

    logic [31:0] mem [0:BANKS-1][0:BANK_DEPTH-1];
    logic [31:0] rd_reg [0:BANKS-1];

    // One word written per cycle while the write enable is set.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.bank][wr.addr] <= wr.data;
        end
    end

    // All four words of one round read together, registered.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < BANKS; c++)
        begin
            rd_reg[c] <= mem[c][rd_addr];
        end
    end

    assign rd_data = {rd_reg[0], rd_reg[1], rd_reg[2], rd_reg[3]};

endmodule

FILE: rtl/aes_round.sv
// One AES round, forward or inverse, with the last round's column mix left out.
// Depends on aes_pkg.
module aes_round (
    input  logic [127:0] state,
    input  logic [127:0] round_key,
    input  logic         decrypt,
    input  logic         last,
    output logic [127:0] result
);
    import aes_pkg::*;

    logic [7:0] s  [0:15];
    logic [7:0] sh [0:15];
    logic [7:0] sb [0:15];
    logic [7:0] pre[0:15];
    logic [7:0] mx [0:15];
    logic [7:0] rk [0:15];
    logic [7:0] o  [0:15];

    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            s[n]  = state[127 - 8 * n -: 8];
            rk[n] = round_key[127 - 8 * n -: 8];
        end
        // Row shift before substitution for the inverse, after it forward.
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (decrypt)
                begin
                    sh[4 * c + r] = s[4 * int'(2'(c - r)) + r];
                end
                else
                begin
                    sh[4 * c + r] = SBOX_FWD[s[4 * int'(2'(c + r)) + r]];
                end
            end
        end
        for (int n = 0; n < 16; n++)
        begin
            sb[n]  = decrypt ? SBOX_INV[sh[n]] : sh[n];
            pre[n] = decrypt ? (sb[n] ^ rk[n]) : sb[n];
        end
        // Column mix on the forward or inverse matrix.
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                mx[4 * c + r] = 8'h00;
                for (int k = 0; k < 4; k++)
                begin
                    mx[4 * c + r] = mx[4 * c + r] ^ gf_mul(pre[4 * c + k],
                        decrypt ? MIX_INV[2'(k - r)] : MIX_FWD[2'(k - r)]);
                end
            end
        end
        for (int n = 0; n < 16; n++)
        begin
            o[n] = last ? pre[n] : mx[n];
            if (!decrypt)
            begin
                o[n] = o[n] ^ rk[n];
            end
            result[127 - 8 * n -: 8] = o[n];
        end
    end

endmodule

FILE: rtl/aes_block_cipher.sv
// AES-128/192/256 ECB block cipher: top level with control and configuration.
// Depends on aes_pkg, aes_in_if, aes_out_if, aes_key_expand, aes_rk_store, aes_round.
// Nr rounds (Nr = 10, 12 or 14), one round per cycle, paced by the one-row read
// of the round-key store. A new item is taken once the previous result sits in
// the output register. After reset and after each write to a register index up
// to REG_KEY_W3, key expansion writes 4*(Nr+1) words, one per cycle, while no
// item is accepted; reset loads the all-zero 128-bit key and expands it.
module aes_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    aes_in_if.sink      blk_in,
    aes_out_if.source   blk_out
);
    import aes_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_KEYADD = 2'd1;
    localparam logic [1:0] ST_ROUND  = 2'd2;
    localparam logic [1:0] ST_WAIT   = 2'd3;

    logic [1:0]   key_size_reg;
    logic [63:0]  key_word_reg [0:3];
    logic [1:0]   state_reg, state_next;
    logic         dec_reg, dec_next;
    logic [127:0] blk_reg, blk_next;
    rk_addr_t     addr_reg, addr_next;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] out_reg;
    logic         kx_start;
    logic         kx_busy;
    rk_wr_t       rk_wr;
    logic [127:0] rk_data;
    logic [127:0] round_out;
    logic [3:0]   nr;
    logic         last;
    logic         in_take;

    // Configuration registers; every write to an index up to REG_KEY_W3 restarts key expansion.
    assign kx_start = cfg_we && cfg_index <= REG_KEY_W3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= KEY_128;
            for (int k = 0; k < 4; k++)
            begin
                key_word_reg[k] <= 64'd0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_KEY_SIZE)
            begin
                key_size_reg <= cfg_data[1:0];
            end
            else if (cfg_index <= REG_KEY_W3)
            begin
                key_word_reg[2'(cfg_index - REG_KEY_W0)] <= cfg_data;
            end
        end
    end

    aes_key_expand u_kx (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kx_start),
        .key_size (key_size_reg),
        .key_word (key_word_reg),
        .busy     (kx_busy),
        .wr       (rk_wr)
    );

    aes_rk_store u_store (
        .clk     (clk),
        .wr      (rk_wr),
        .rd_addr (addr_next),
        .rd_data (rk_data)
    );

    aes_round u_round (
        .state     (blk_reg),
        .round_key (rk_data),
        .decrypt   (dec_reg),
        .last      (last),
        .result    (round_out)
    );

    assign nr      = round_count(key_size_reg);
    assign last    = dec_reg ? (addr_reg == 4'd0) : (addr_reg == nr);
    assign in_take = blk_in.valid && blk_in.ready;

    // Round sequencer; the store address is registered ahead of the round.
    always_comb
    begin
        state_next     = state_reg;
        dec_next       = dec_reg;
        blk_next       = blk_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !blk_out.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    dec_next   = blk_in.opcode;
                    blk_next   = {blk_in.block_upper, blk_in.block_lower};
                    addr_next  = blk_in.opcode ? nr : 4'd0;
                    state_next = ST_KEYADD;
                end
            end
            ST_KEYADD:
            begin
                blk_next   = blk_reg ^ rk_data;
                addr_next  = dec_reg ? addr_reg - 4'd1 : addr_reg + 4'd1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                blk_next = round_out;
                if (last)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    addr_next = dec_reg ? addr_reg - 4'd1 : addr_reg + 4'd1;
                end
            end
            ST_WAIT:
            begin
                if (!out_valid_reg || blk_out.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            addr_reg      <= 4'd0;
            dec_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            addr_reg      <= addr_next;
            dec_reg       <= dec_next;
        end
    end

    // Block state and output register.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (state_reg == ST_WAIT && (!out_valid_reg || blk_out.ready))
        begin
            out_reg <= blk_reg;
        end
    end

    assign blk_in.ready      = (state_reg == ST_IDLE) && !kx_busy;
    assign blk_out.valid     = out_valid_reg;
    assign blk_out.out_upper = out_reg[127:64];
    assign blk_out.out_lower = out_reg[63:0];

endmodule
